// File: rtl/hbrd_pkg.sv
// Shared constants, types and register indexes of the heart beat rate detector.
// No dependencies; every other file refers to it by scoped names.
package hbrd_pkg;

  // Depth of the R-R interval ring
  localparam int RR_DEPTH = 4;
  localparam int RR_W     = (RR_DEPTH > 1) ? $clog2(RR_DEPTH) : 1;
  localparam int HELD_W   = $clog2(RR_DEPTH + 1);
  localparam int SUM_W    = 16 + $clog2(RR_DEPTH);
  localparam int DIV_W    = SUM_W;
  localparam int DCNT_W   = $clog2(DIV_W + 1);

  // Job queue depth; keep it a power of two so the pointers wrap on their own
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [15:0] BPM_NUMERATOR = 16'd60000;

  // Configuration register indexes
  localparam logic [2:0] REG_THRESHOLD = 3'd0;
  localparam logic [2:0] REG_REFRACT   = 3'd1;
  localparam logic [2:0] REG_TIMEOUT   = 3'd2;
  localparam logic [2:0] REG_LED_PULSE = 3'd3;
  localparam logic [2:0] REG_LOW_RATE  = 3'd4;
  localparam logic [2:0] REG_HIGH_RATE = 3'd5;

  // Reset values
  localparam logic [9:0]  RST_THRESHOLD = 10'd600;
  localparam logic [15:0] RST_REFRACT   = 16'd250;
  localparam logic [15:0] RST_TIMEOUT   = 16'd3000;
  localparam logic [15:0] RST_LED_PULSE = 16'd50;
  localparam logic [15:0] RST_LOW_RATE  = 16'd40;
  localparam logic [15:0] RST_HIGH_RATE = 16'd180;

  // Rate classes
  localparam logic [1:0] CLASS_NONE = 2'd0;
  localparam logic [1:0] CLASS_LOW  = 2'd1;
  localparam logic [1:0] CLASS_OK   = 2'd2;
  localparam logic [1:0] CLASS_HIGH = 2'd3;

  typedef struct packed {
    logic [9:0]  threshold;
    logic [15:0] refract;
    logic [15:0] timeout;
    logic [15:0] led_pulse;
    logic [15:0] low_rate;
    logic [15:0] high_rate;
  } cfg_t;

  // One classified sample waiting for the rate computation
  typedef struct packed {
    logic [9:0]        gated;
    logic              beat;
    logic              led;
    logic              rate_ok;
    logic [SUM_W-1:0]  sum;
    logic [HELD_W-1:0] held;
  } job_t;

endpackage

// File: rtl/hbrd_front.sv
// Front end: beat classification, R-R ring, running interval sum and LED countdown.
// Depends on hbrd_pkg.
module hbrd_front (
  input  logic                clk,
  input  logic                rst,
  input  hbrd_pkg::cfg_t      cfg,
  input  logic                push,
  input  logic [9:0]          adc_sample,
  input  logic [31:0]         time_ms,
  output hbrd_pkg::job_t      job
);

  logic [15:0]                 store [hbrd_pkg::RR_DEPTH];
  logic [hbrd_pkg::RR_W-1:0]   slot;
  logic [hbrd_pkg::HELD_W-1:0] held;
  logic [hbrd_pkg::SUM_W-1:0]  sum;
  logic [31:0]                 last_beat;
  logic                        seen;
  logic [15:0]                 led_cnt;

  logic [hbrd_pkg::RR_W-1:0]   slot_next;
  logic [hbrd_pkg::HELD_W-1:0] held_next;
  logic [hbrd_pkg::SUM_W-1:0]  sum_next;
  logic [15:0]                 led_next;
  logic [31:0]                 since;
  logic [31:0]                 since_out;
  logic                        in_refr;
  logic                        beat;
  logic                        store_iv;
  logic                        full;
  logic [15:0]                 led_load;
  logic [15:0]                 led_base;

  always_comb begin
    since     = time_ms - last_beat;
    in_refr   = seen && (since < {16'd0, cfg.refract});
    beat      = !in_refr && (adc_sample > cfg.threshold);
    store_iv  = beat && seen;
    full      = (held == hbrd_pkg::HELD_W'(hbrd_pkg::RR_DEPTH));
    led_load  = (cfg.led_pulse == 16'd0) ? 16'd1 : cfg.led_pulse;
    led_base  = beat ? led_load : led_cnt;
    if (in_refr) begin
      led_next = led_cnt;
    end else begin
      led_next = (led_base != 16'd0) ? led_base - 16'd1 : 16'd0;
    end
    slot_next = (slot == hbrd_pkg::RR_W'(hbrd_pkg::RR_DEPTH - 1)) ?
                '0 : slot + hbrd_pkg::RR_W'(1);
    held_next = (store_iv && !full) ? held + hbrd_pkg::HELD_W'(1) : held;
    // replace the oldest interval in the running sum once the ring is full
    sum_next  = sum;
    if (store_iv) begin
      sum_next = sum + hbrd_pkg::SUM_W'(since[15:0])
                 - (full ? hbrd_pkg::SUM_W'(store[slot]) : '0);
    end
    since_out   = beat ? 32'd0 : since;
    job.gated   = beat ? adc_sample : 10'd0;
    job.beat    = beat;
    job.led     = (led_next != 16'd0);
    job.rate_ok = (held_next >= hbrd_pkg::HELD_W'(2)) &&
                  (since_out <= {16'd0, cfg.timeout});
    job.sum     = sum_next;
    job.held    = held_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot      <= '0;
      held      <= '0;
      sum       <= '0;
      last_beat <= 32'd0;
      seen      <= 1'b0;
      led_cnt   <= 16'd0;
    end else if (push) begin
      led_cnt <= led_next;
      held    <= held_next;
      sum     <= sum_next;
      if (store_iv) begin
        slot <= slot_next;
      end
      if (beat) begin
        last_beat <= time_ms;
        seen      <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push && store_iv) begin
      store[slot] <= since[15:0];
    end
  end

endmodule

// File: rtl/hbrd_queue.sv
// Two-entry job queue between the front end and the rate unit.
// Depends on hbrd_pkg.
module hbrd_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  hbrd_pkg::job_t push_job,
  input  logic           pop,
  output hbrd_pkg::job_t head,
  output logic           full,
  output logic           empty
);

  hbrd_pkg::job_t              entries [hbrd_pkg::QUEUE_DEPTH];
  logic [hbrd_pkg::QPTR_W-1:0] wr_ptr;
  logic [hbrd_pkg::QPTR_W-1:0] rd_ptr;
  logic [hbrd_pkg::QCNT_W-1:0] count;

  assign full  = (count == hbrd_pkg::QCNT_W'(hbrd_pkg::QUEUE_DEPTH));
  assign empty = (count == '0);
  assign head  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + hbrd_pkg::QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + hbrd_pkg::QPTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + hbrd_pkg::QCNT_W'(1);
      end else if (pop && !push) begin
        count <= count - hbrd_pkg::QCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    (full && !pop) |-> !push)
    else $error("queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    empty |-> !pop)
    else $error("queue read while empty");

endmodule

// File: rtl/hbrd_div.sv
// Restoring divider, one quotient bit per cycle, shared by both rate divisions.
// Depends on hbrd_pkg.
module hbrd_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [hbrd_pkg::DIV_W-1:0] dividend,
  input  logic [15:0]                divisor,
  output logic                       busy,
  output logic                       done,
  output logic [hbrd_pkg::DIV_W-1:0] quotient
);

  logic [15:0]                 dsr;
  logic [15:0]                 rem;
  logic [hbrd_pkg::DCNT_W-1:0] cnt;
  logic [16:0]                 rem_sh;
  logic                        ge;
  logic [16:0]                 rem_sub;

  always_comb begin
    rem_sh  = {rem, quotient[hbrd_pkg::DIV_W-1]};
    ge      = (rem_sh >= {1'b0, dsr});
    rem_sub = rem_sh - {1'b0, dsr};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= !start && busy && (cnt == hbrd_pkg::DCNT_W'(1));
      if (start) begin
        busy <= 1'b1;
        cnt  <= hbrd_pkg::DCNT_W'(hbrd_pkg::DIV_W);
      end else if (busy) begin
        cnt <= cnt - hbrd_pkg::DCNT_W'(1);
        if (cnt == hbrd_pkg::DCNT_W'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quotient <= dividend;
      dsr      <= divisor;
      rem      <= 16'd0;
    end else if (busy) begin
      quotient <= {quotient[hbrd_pkg::DIV_W-2:0], ge};
      rem      <= ge ? rem_sub[15:0] : rem_sh[15:0];
    end
  end

endmodule

// File: rtl/hbrd_back.sv
// Back end: mean interval and beats per minute through the shared divider,
// rate class and the output register. Depends on hbrd_pkg and hbrd_div.
module hbrd_back (
  input  logic           clk,
  input  logic           rst,
  input  hbrd_pkg::cfg_t cfg,
  input  hbrd_pkg::job_t head,
  input  logic           empty,
  output logic           pop,
  output logic           out_valid,
  input  logic           out_stall,
  output logic [9:0]     gated_sample,
  output logic           beat_found,
  output logic           led_lit,
  output logic [15:0]    beats_per_minute,
  output logic [1:0]     rate_class
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_MEAN = 2'd1;
  localparam logic [1:0] S_RATE = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0]                 state;
  hbrd_pkg::job_t             job;
  logic [15:0]                bpm;
  logic                       div_start;
  logic [hbrd_pkg::DIV_W-1:0] div_dividend;
  logic [15:0]                div_divisor;
  logic                       div_busy;
  logic                       div_done;
  logic [hbrd_pkg::DIV_W-1:0] div_quo;
  logic [15:0]                mean;
  logic                       out_free;
  logic [1:0]                 cls;

  assign pop      = (state == S_IDLE) && !empty;
  assign mean     = div_quo[15:0];
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    div_start    = 1'b0;
    div_dividend = head.sum;
    div_divisor  = 16'(head.held);
    if (pop) begin
      div_start = head.rate_ok;
    end else if ((state == S_MEAN) && div_done && (mean != 16'd0)) begin
      div_start    = 1'b1;
      div_dividend = hbrd_pkg::DIV_W'(hbrd_pkg::BPM_NUMERATOR);
      div_divisor  = mean;
    end
  end

  always_comb begin
    if (bpm == 16'd0) begin
      cls = hbrd_pkg::CLASS_NONE;
    end else if (bpm < cfg.low_rate) begin
      cls = hbrd_pkg::CLASS_LOW;
    end else if (bpm > cfg.high_rate) begin
      cls = hbrd_pkg::CLASS_HIGH;
    end else begin
      cls = hbrd_pkg::CLASS_OK;
    end
  end

  hbrd_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_quo)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      // raise on a finished job, hold while stalled, drop once taken
      out_valid <= ((state == S_DONE) && out_free) || (out_valid && out_stall);
      case (state)
        S_IDLE: begin
          if (pop) begin
            state <= head.rate_ok ? S_MEAN : S_DONE;
          end
        end
        S_MEAN: begin
          if (div_done) begin
            state <= (mean != 16'd0) ? S_RATE : S_DONE;
          end
        end
        S_RATE: begin
          if (div_done) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      job <= head;
      bpm <= 16'd0;
    end else if ((state == S_RATE) && div_done) begin
      bpm <= div_quo[15:0];
    end
    if ((state == S_DONE) && out_free) begin
      gated_sample     <= job.gated;
      beat_found       <= job.beat;
      led_lit          <= job.led;
      beats_per_minute <= bpm;
      rate_class       <= cls;
    end
  end

  a_hold_done: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && out_valid && out_stall) |=> (state == S_DONE))
    else $error("result dropped while output stalled");
  a_div_running: assert property (@(posedge clk) disable iff (rst)
    (state == S_MEAN || state == S_RATE) |-> (div_busy || div_done))
    else $error("waiting on an idle divider");

endmodule

// File: rtl/heart_beat_rate_detector_core.sv
// Top level of the heart beat rate detector: configuration registers, front end,
// job queue and rate unit. Depends on hbrd_pkg, hbrd_front, hbrd_queue, hbrd_back.

// Threshold beat detector with R-R averaging. Each request carries one 10-bit
// ADC sample and its millisecond timestamp and yields exactly one result: the
// gated sample, a beat flag, the LED level, beats per minute (60000 over the
// truncated mean of up to RR_DEPTH stored intervals) and a rate class. The
// front end classifies a sample in the cycle it is accepted and updates the
// interval ring and a running interval sum at once; the request then waits in
// a two-deep queue for the rate unit. The rate unit runs two divisions, sum by
// count and 60000 by mean, on one restoring divider at one bit per cycle, and
// a sample without a valid rate skips both. Sustained throughput is set by
// that divider; the queue and the output register let a sample be accepted
// while an earlier result waits on a stalled output. Write configuration only
// while the block is idle; writes to an index beyond the register list are
// ignored.
module heart_beat_rate_detector_core (
  input  logic        clk,
  input  logic        rst,
  // configuration write port
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  // sample channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [9:0]  adc_sample,
  input  logic [31:0] time_ms,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [9:0]  gated_sample,
  output logic        beat_found,
  output logic        led_lit,
  output logic [15:0] beats_per_minute,
  output logic [1:0]  rate_class
);

  hbrd_pkg::cfg_t cfg;
  hbrd_pkg::job_t push_job;
  hbrd_pkg::job_t head;
  logic           push;
  logic           pop;
  logic           q_full;
  logic           q_empty;

  // Hold the sample channel only while the queue has no room
  assign in_stall = q_full;
  assign push     = in_valid && !q_full;

  // Configuration registers, cropped to their widths
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.threshold <= hbrd_pkg::RST_THRESHOLD;
      cfg.refract   <= hbrd_pkg::RST_REFRACT;
      cfg.timeout   <= hbrd_pkg::RST_TIMEOUT;
      cfg.led_pulse <= hbrd_pkg::RST_LED_PULSE;
      cfg.low_rate  <= hbrd_pkg::RST_LOW_RATE;
      cfg.high_rate <= hbrd_pkg::RST_HIGH_RATE;
    end else if (cfg_we) begin
      case (cfg_index)
        hbrd_pkg::REG_THRESHOLD: cfg.threshold <= cfg_data[9:0];
        hbrd_pkg::REG_REFRACT:   cfg.refract   <= cfg_data;
        hbrd_pkg::REG_TIMEOUT:   cfg.timeout   <= cfg_data;
        hbrd_pkg::REG_LED_PULSE: cfg.led_pulse <= cfg_data;
        hbrd_pkg::REG_LOW_RATE:  cfg.low_rate  <= cfg_data;
        hbrd_pkg::REG_HIGH_RATE: cfg.high_rate <= cfg_data;
        default: ;
      endcase
    end
  end

  hbrd_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .push       (push),
    .adc_sample (adc_sample),
    .time_ms    (time_ms),
    .job        (push_job)
  );

  hbrd_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head     (head),
    .full     (q_full),
    .empty    (q_empty)
  );

  hbrd_back u_back (
    .clk              (clk),
    .rst              (rst),
    .cfg              (cfg),
    .head             (head),
    .empty            (q_empty),
    .pop              (pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .gated_sample     (gated_sample),
    .beat_found       (beat_found),
    .led_lit          (led_lit),
    .beats_per_minute (beats_per_minute),
    .rate_class       (rate_class)
  );

  a_class_matches_rate: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((beats_per_minute == 16'd0) == (rate_class == hbrd_pkg::CLASS_NONE)))
    else $error("rate class disagrees with zero rate");

endmodule

// File: test/tb_heart_beat_rate_detector_core.sv
// Self-checking testbench for heart_beat_rate_detector_core: directed and random sample
// streams, each result checked against a cycle-free beat and rate predictor.
// Depends on hbrd_pkg and the core RTL only.
module tb_heart_beat_rate_detector_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT = 500000;
  localparam int unsigned BURST_HOLD  = 300;
  localparam int unsigned TAIL_CYCLES = 60;
  localparam int unsigned PHASES      = 6;
  localparam int unsigned PHASE_ITEMS = 95;
  // Indexes past the register list; writes there must change nothing
  localparam logic [2:0]  NO_REG_A    = 3'd6;
  localparam logic [2:0]  NO_REG_B    = 3'd7;

  typedef struct packed {
    logic [9:0]  sample;
    logic [31:0] ms;
  } sample_req_t;

  typedef struct packed {
    logic [9:0]  gated;
    logic        beat;
    logic        led;
    logic [15:0] bpm;
    logic [1:0]  cls;
  } beat_report_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [9:0]  adc_sample = '0;
  logic [31:0] time_ms = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [9:0]  gated_sample;
  logic        beat_found;
  logic        led_lit;
  logic [15:0] beats_per_minute;
  logic [1:0]  rate_class;

  heart_beat_rate_detector_core i_dut (
    .clk              (clk),
    .rst              (rst),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .adc_sample       (adc_sample),
    .time_ms          (time_ms),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .gated_sample     (gated_sample),
    .beat_found       (beat_found),
    .led_lit          (led_lit),
    .beats_per_minute (beats_per_minute),
    .rate_class       (rate_class)
  );

  always #5 clk = ~clk;

  int unsigned cycle_count = 0;
  always @(posedge clk) cycle_count <= cycle_count + 1;

  // Requests waiting for the driver, and reports waiting for the monitor
  sample_req_t  sample_backlog[$];
  beat_report_t report_fifo[$];

  // Idle percentages per side; changed only at a falling edge
  int unsigned send_idle_pct = 25;
  int unsigned recv_idle_pct = 57;
  // The stimulus orders a long receiver hold-off; the monitor serves it
  int unsigned burst_orders = 0;
  int unsigned burst_served = 0;
  int unsigned burst_left   = 0;

  int unsigned errors          = 0;
  int unsigned reports_checked = 0;
  int unsigned queued_total    = 0;
  int unsigned beats_expected  = 0;
  int unsigned rated_reports   = 0;
  int unsigned settings_used   = 0;
  logic [31:0] clock_ms        = '0;

  // Predictor state: a mirror of the registers plus the detector's own state
  hbrd_pkg::cfg_t mirror_cfg;
  logic [15:0]    rr_ring [hbrd_pkg::RR_DEPTH];
  int unsigned    ring_slot;
  int unsigned    ring_count;
  logic [31:0]    prev_beat_ms;
  logic           beat_seen;
  logic [15:0]    led_left;

  function automatic void reset_mirror();
    mirror_cfg.threshold = hbrd_pkg::RST_THRESHOLD;
    mirror_cfg.refract   = hbrd_pkg::RST_REFRACT;
    mirror_cfg.timeout   = hbrd_pkg::RST_TIMEOUT;
    mirror_cfg.led_pulse = hbrd_pkg::RST_LED_PULSE;
    mirror_cfg.low_rate  = hbrd_pkg::RST_LOW_RATE;
    mirror_cfg.high_rate = hbrd_pkg::RST_HIGH_RATE;
    foreach (rr_ring[k]) rr_ring[k] = '0;
    ring_slot    = 0;
    ring_count   = 0;
    prev_beat_ms = '0;
    beat_seen    = 1'b0;
    led_left     = '0;
  endfunction

  // Classify one sample, update the interval ring and LED countdown, and
  // work out the rate that the block must report for it.
  function automatic beat_report_t detect_beat(logic [9:0] sample, logic [31:0] now);
    beat_report_t rep;
    logic [31:0]  since;
    logic [31:0]  quiet;
    int unsigned  sum;
    int unsigned  mean;
    int unsigned  rate;
    int unsigned  k;
    rep = '0;
    since = now - prev_beat_ms;
    rep.gated = (sample > mirror_cfg.threshold) ? sample : 10'd0;
    if (beat_seen && since < 32'(mirror_cfg.refract)) begin
      // blanked: no beat and the LED countdown holds
      rep.gated = '0;
    end else begin
      if (rep.gated != '0) begin
        rep.beat = 1'b1;
        if (beat_seen) begin
          rr_ring[ring_slot] = since[15:0];
          ring_slot = (ring_slot + 1) % hbrd_pkg::RR_DEPTH;
          if (ring_count < hbrd_pkg::RR_DEPTH) ring_count++;
        end
        prev_beat_ms = now;
        beat_seen    = 1'b1;
        led_left     = (mirror_cfg.led_pulse != '0) ? mirror_cfg.led_pulse : 16'd1;
      end
      if (led_left != '0) led_left--;
    end
    rep.led = (led_left != '0);
    rate  = 0;
    quiet = now - prev_beat_ms;
    if (ring_count >= 2 && quiet <= 32'(mirror_cfg.timeout)) begin
      sum = 0;
      for (k = 0; k < ring_count; k++) sum += rr_ring[k];
      mean = (sum / ring_count) & 32'h0000_FFFF;
      if (mean != 0) rate = 60000 / mean;
    end
    rep.bpm = rate[15:0];
    if (rate == 0) begin
      rep.cls = hbrd_pkg::CLASS_NONE;
    end else if (rate < mirror_cfg.low_rate) begin
      rep.cls = hbrd_pkg::CLASS_LOW;
    end else if (rate > mirror_cfg.high_rate) begin
      rep.cls = hbrd_pkg::CLASS_HIGH;
    end else begin
      rep.cls = hbrd_pkg::CLASS_OK;
    end
    if (rep.beat) beats_expected++;
    if (rate != 0) rated_reports++;
    return rep;
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
    end
  endfunction

  // Driver: predict each accepted request, then offer the next one unless the
  // sender idles. A stalled request holds its payload.
  always @(posedge clk) begin
    sample_req_t req;
    logic        holding;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      holding = in_valid;
      if (in_valid && !in_stall) begin
        report_fifo.push_back(detect_beat(adc_sample, time_ms));
        holding = 1'b0;
      end
      if (!holding) begin
        if (sample_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          req = sample_backlog.pop_front();
          in_valid   <= 1'b1;
          adc_sample <= req.sample;
          time_ms    <= req.ms;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each accepted result against the oldest expectation, then
  // choose the stall for the next cycle.
  always @(posedge clk) begin
    beat_report_t want;
    if (!rst && out_valid && !out_stall) begin
      if (report_fifo.size() == 0) begin
        errors++;
        $display("%0t: result with nothing expected, gated %0d bpm %0d",
                 $time, gated_sample, beats_per_minute);
      end else begin
        want = report_fifo.pop_front();
        reports_checked++;
        check_field("gated_sample", want.gated, gated_sample);
        check_field("beat_found", want.beat, beat_found);
        check_field("led_lit", want.led, led_lit);
        check_field("beats_per_minute", want.bpm, beats_per_minute);
        check_field("rate_class", want.cls, rate_class);
      end
    end
    if (burst_left != 0) begin
      burst_left--;
      out_stall <= 1'b1;
    end else if (burst_served != burst_orders) begin
      burst_served++;
      burst_left = BURST_HOLD - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [15:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      hbrd_pkg::REG_THRESHOLD: mirror_cfg.threshold = val[9:0];
      hbrd_pkg::REG_REFRACT:   mirror_cfg.refract   = val;
      hbrd_pkg::REG_TIMEOUT:   mirror_cfg.timeout   = val;
      hbrd_pkg::REG_LED_PULSE: mirror_cfg.led_pulse = val;
      hbrd_pkg::REG_LOW_RATE:  mirror_cfg.low_rate  = val;
      hbrd_pkg::REG_HIGH_RATE: mirror_cfg.high_rate = val;
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic apply_settings(logic [15:0] thr, logic [15:0] refr, logic [15:0] tmo,
                                logic [15:0] led, logic [15:0] low, logic [15:0] high);
    write_reg(hbrd_pkg::REG_THRESHOLD, thr);
    write_reg(hbrd_pkg::REG_REFRACT, refr);
    write_reg(hbrd_pkg::REG_TIMEOUT, tmo);
    write_reg(hbrd_pkg::REG_LED_PULSE, led);
    write_reg(hbrd_pkg::REG_LOW_RATE, low);
    write_reg(hbrd_pkg::REG_HIGH_RATE, high);
    settings_used++;
    @(negedge clk);
  endtask

  // Sender pause: wait for the backlog, the channel and every report to clear
  task automatic wait_drained();
    while (sample_backlog.size() != 0 || in_valid || report_fifo.size() != 0)
      @(negedge clk);
  endtask

  function automatic void push_request(logic [9:0] sample, logic [31:0] ms);
    sample_req_t req;
    req.sample = sample;
    req.ms     = ms;
    sample_backlog.push_back(req);
    queued_total++;
  endfunction

  function automatic logic [9:0] peak_sample();
    if (mirror_cfg.threshold == 10'd1023) return 10'd1023;
    return 10'($urandom_range(1023, int'(mirror_cfg.threshold) + 1));
  endfunction

  function automatic logic [9:0] floor_sample();
    return 10'($urandom_range(int'(mirror_cfg.threshold), 0));
  endfunction

  // One well-formed stretch of heartbeat: a peak per beat period, baseline
  // samples in between, now and then a second peak that falls in the blanking
  // window or lands as an early beat.
  function automatic void queue_beat_train();
    int unsigned period;
    int unsigned steps;
    int unsigned beats;
    int unsigned b;
    int unsigned s;
    logic [9:0]  level;
    period = ($urandom_range(7) == 0) ? $urandom_range(300, 20) : $urandom_range(1600, 300);
    steps  = $urandom_range(4, 1);
    beats  = $urandom_range(8, 3);
    for (b = 0; b < beats; b++) begin
      for (s = 0; s < steps; s++) begin
        if (s == 0 || $urandom_range(5) == 0) level = peak_sample();
        else level = floor_sample();
        push_request(level, clock_ms + s * (period / steps));
      end
      clock_ms = clock_ms + period + $urandom_range(40);
    end
  endfunction

  function automatic void queue_random_requests(int unsigned count);
    int unsigned target;
    int unsigned pick;
    target = queued_total + count;
    while (queued_total < target) begin
      pick = $urandom_range(19);
      if (pick == 0) begin
        // noise: any sample at any timestamp, and carry on from there
        clock_ms = $urandom();
        push_request(10'($urandom_range(1023)), clock_ms);
      end else if (pick == 1) begin
        // drop-out long enough to time out or to truncate the next interval
        clock_ms = clock_ms + $urandom_range(140000, 3000);
      end else if (pick == 2) begin
        // jump close to the timestamp wrap
        clock_ms = 32'hFFFF_FFFF - $urandom_range(4000);
      end else begin
        queue_beat_train();
      end
    end
  endfunction

  initial begin
    int unsigned phase;
    reset_mirror();
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Reset settings: quiet start, first beat, blanking, sample equal to the
    // threshold, a single interval, a valid rate, timeout, a truncated long
    // interval, the timestamp wrap and both edges of the blanking window.
    push_request(10'd0, 32'd0);
    push_request(10'd1023, 32'd0);
    push_request(10'd601, 32'd100);
    push_request(10'd600, 32'd300);
    push_request(10'd700, 32'd800);
    push_request(10'd1023, 32'd1600);
    push_request(10'd1023, 32'd1700);
    push_request(10'd100, 32'd4601);
    push_request(10'd800, 32'd71600);
    push_request(10'd900, 32'hFFFF_FF00);
    push_request(10'd900, 32'h0000_0100);
    push_request(10'd1023, 32'h0000_01FA);
    push_request(10'd900, 32'h0000_02F3);
    wait_drained();

    // Zero threshold and blanking, pulse length zero, low and high classes
    // overlapping; also hit both unused indexes. Repeated beats at one
    // timestamp fill the ring with zero intervals.
    write_reg(NO_REG_A, 16'hFFFF);
    write_reg(NO_REG_B, 16'hFFFF);
    apply_settings(16'd0, 16'd0, 16'hFFFF, 16'd0, 16'hFFFF, 16'd0);
    repeat (5) push_request(10'd1023, 32'd5000);
    push_request(10'd1, 32'd5001);
    push_request(10'd1, 32'd5002);
    push_request(10'd0, 32'd5002);
    wait_drained();

    // Widest blanking, zero timeout, longest pulse, widest class band
    apply_settings(16'd500, 16'hFFFF, 16'd0, 16'hFFFF, 16'd0, 16'hFFFF);
    push_request(10'd900, 32'd10000);
    push_request(10'd900, 32'd70537);
    push_request(10'd900, 32'd70538);
    wait_drained();
    write_reg(hbrd_pkg::REG_THRESHOLD, 16'hFFFF);
    @(negedge clk);
    push_request(10'd1023, 32'd200000);
    wait_drained();

    // Random phases: sender-light idling, then receiver-light, then none
    for (phase = 0; phase < PHASES; phase++) begin
      if (phase == 0) begin
        apply_settings(16'(hbrd_pkg::RST_THRESHOLD), hbrd_pkg::RST_REFRACT,
                       hbrd_pkg::RST_TIMEOUT, hbrd_pkg::RST_LED_PULSE,
                       hbrd_pkg::RST_LOW_RATE, hbrd_pkg::RST_HIGH_RATE);
      end else begin
        apply_settings(16'($urandom_range(900, 200)), 16'($urandom_range(400)),
                       16'($urandom_range(65535, 800)), 16'($urandom_range(80, 1)),
                       16'($urandom_range(80, 20)), 16'($urandom_range(250, 100)));
      end
      send_idle_pct = (phase < 2) ? 25 : (phase < 4) ? 57 : 0;
      recv_idle_pct = (phase < 2) ? 57 : (phase < 4) ? 25 : 0;
      if (phase == 3) begin
        // pause the sender halfway until every report is back
        queue_random_requests(PHASE_ITEMS / 2);
        wait_drained();
        queue_random_requests(PHASE_ITEMS - PHASE_ITEMS / 2);
      end else begin
        queue_random_requests(PHASE_ITEMS);
      end
      // hold the receiver off while the backlog is full so the block backs up
      if (phase == 1) burst_orders++;
      wait_drained();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    @(negedge clk);
    if (report_fifo.size() != 0) begin
      errors += report_fifo.size();
      $display("%0t: %0d expected reports never arrived", $time, report_fifo.size());
    end
    $display("Run covered %0d samples over %0d register settings, %0d reports checked,",
             queued_total, settings_used, reports_checked);
    $display("with %0d beats and %0d reports carrying a rate.", beats_expected, rated_reports);
    if (errors == 0) begin
      $display("tb_heart_beat_rate_detector_core: done, clean");
    end else begin
      $display("tb_heart_beat_rate_detector_core: done, errors");
    end
    $finish;
  end

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("%0t: run exceeded %0d cycles", $time, CYCLE_LIMIT);
    $display("tb_heart_beat_rate_detector_core: done, errors");
    $finish;
  end

endmodule
